// ===== rtl/alert_tone_pattern_generator_defines.svh =====
// assertion helpers for the rtl files, included by atpg_core
`ifndef ALERT_TONE_PATTERN_GENERATOR_DEFINES_SVH
`define ALERT_TONE_PATTERN_GENERATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ATPG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("atpg check failed");

// next-cycle implication, checked outside reset
`define ATPG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("atpg check failed");

`endif

// ===== rtl/atpg_pkg.sv =====
package atpg_pkg;

    localparam int unsigned REG_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        ALERT_SAFE   = 2'd0,
        ALERT_WARN   = 2'd1,
        ALERT_DANGER = 2'd2,
        ALERT_ERROR  = 2'd3
    } t_alert;

    typedef enum logic [1:0] {
        STEP_ON1   = 2'd0,
        STEP_GAP   = 2'd1,
        STEP_ON2   = 2'd2,
        STEP_PAUSE = 2'd3
    } t_beep_step;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARN_HALF   = 3'd0,
        CFG_DANGER_HALF = 3'd1,
        CFG_ERROR_HALF  = 3'd2,
        CFG_BEEP_ON     = 3'd3,
        CFG_BEEP_GAP    = 3'd4,
        CFG_BEEP_PAUSE  = 3'd5
    } t_cfg_idx;

    localparam logic [REG_W-1:0] RST_WARN_HALF   = 16'd2;
    localparam logic [REG_W-1:0] RST_DANGER_HALF = 16'd1;
    localparam logic [REG_W-1:0] RST_ERROR_HALF  = 16'd1;
    localparam logic [REG_W-1:0] RST_BEEP_ON     = 16'd800;
    localparam logic [REG_W-1:0] RST_BEEP_GAP    = 16'd1200;
    localparam logic [REG_W-1:0] RST_BEEP_PAUSE  = 16'd6000;

    typedef struct packed {
        logic [REG_W-1:0] warn_half_period;
        logic [REG_W-1:0] danger_half_period;
        logic [REG_W-1:0] error_half_period;
        logic [REG_W-1:0] beep_on_ticks;
        logic [REG_W-1:0] beep_gap_ticks;
        logic [REG_W-1:0] beep_pause_ticks;
    } t_atpg_cfg;

    typedef struct packed {
        logic       func;
        logic [1:0] alert_level;
    } t_atpg_in_word;

    typedef struct packed {
        logic       buzzer_level;
        logic [1:0] beep_phase;
    } t_atpg_out_word;

    typedef struct packed {
        logic             tone_enable;
        logic             pattern_mode;
        logic [REG_W-1:0] half_period;
        logic [REG_W-1:0] tone_count;
        logic [REG_W-1:0] phase_count;
        t_beep_step       beep_step;
        logic             pin_level;
        t_alert           current_alert;
    } t_atpg_state;

endpackage

// ===== rtl/atpg_if.sv =====
// input word channel
interface atpg_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [1:0] alert_level;

    modport source (output valid, output func, output alert_level, input ready);
    modport sink   (input valid, input func, input alert_level, output ready);
endinterface

// result word channel
interface atpg_out_if;
    logic       valid;
    logic       ready;
    logic       buzzer_level;
    logic [1:0] beep_phase;

    modport source (output valid, output buzzer_level, output beep_phase, input ready);
    modport sink   (input valid, input buzzer_level, input beep_phase, output ready);
endinterface

// ===== rtl/atpg_cfg_regs.sv =====
module atpg_cfg_regs
    import atpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    output t_atpg_cfg            o_cfg
);

    t_atpg_cfg r_cfg;
    t_atpg_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WARN_HALF:   n_cfg.warn_half_period   = i_cfg_data;
                CFG_DANGER_HALF: n_cfg.danger_half_period = i_cfg_data;
                CFG_ERROR_HALF:  n_cfg.error_half_period  = i_cfg_data;
                CFG_BEEP_ON:     n_cfg.beep_on_ticks      = i_cfg_data;
                CFG_BEEP_GAP:    n_cfg.beep_gap_ticks     = i_cfg_data;
                CFG_BEEP_PAUSE:  n_cfg.beep_pause_ticks   = i_cfg_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warn_half_period   <= RST_WARN_HALF;
            r_cfg.danger_half_period <= RST_DANGER_HALF;
            r_cfg.error_half_period  <= RST_ERROR_HALF;
            r_cfg.beep_on_ticks      <= RST_BEEP_ON;
            r_cfg.beep_gap_ticks     <= RST_BEEP_GAP;
            r_cfg.beep_pause_ticks   <= RST_BEEP_PAUSE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/atpg_core.sv =====
`include "alert_tone_pattern_generator_defines.svh"

module atpg_core
    import atpg_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  t_atpg_in_word  i_word,
    input  t_atpg_cfg      i_cfg,
    output t_atpg_out_word o_result
);

    t_atpg_state r_state;
    t_atpg_state n_state;

    logic [REG_W-1:0] phase_inc;
    logic [REG_W-1:0] tone_base;
    logic [REG_W-1:0] tone_inc;
    logic             pin_base;
    logic             on_end;
    logic             tone_run;

    assign phase_inc = r_state.phase_count + 16'd1;

    // next state for one word
    always_comb begin
        n_state  = r_state;
        on_end   = 1'b0;
        tone_run = 1'b0;
        tone_base = r_state.tone_count;
        tone_inc  = '0;
        pin_base  = r_state.pin_level;
        if (i_word.func) begin
            n_state.current_alert = t_alert'(i_word.alert_level);
            case (t_alert'(i_word.alert_level))
                ALERT_SAFE: begin
                    n_state.tone_enable  = 1'b0;
                    n_state.pattern_mode = 1'b0;
                    n_state.pin_level    = 1'b0;
                end
                ALERT_WARN: begin
                    n_state.tone_enable  = 1'b1;
                    n_state.pattern_mode = 1'b1;
                    n_state.half_period  = i_cfg.warn_half_period;
                    n_state.phase_count  = '0;
                    n_state.beep_step    = STEP_ON1;
                end
                ALERT_DANGER: begin
                    n_state.tone_enable  = 1'b1;
                    n_state.pattern_mode = 1'b0;
                    n_state.half_period  = i_cfg.danger_half_period;
                end
                default: begin
                    n_state.tone_enable  = 1'b1;
                    n_state.pattern_mode = 1'b1;
                    n_state.half_period  = i_cfg.error_half_period;
                    n_state.phase_count  = '0;
                    n_state.beep_step    = STEP_ON1;
                end
            endcase
        end else if (!r_state.tone_enable || (r_state.half_period == '0)) begin
            n_state.tone_count = '0;
        end else begin
            tone_run = 1'b1;
            if (r_state.pattern_mode && (r_state.current_alert == ALERT_WARN)) begin
                n_state.phase_count = phase_inc;
                case (r_state.beep_step)
                    STEP_ON1: begin
                        if (phase_inc >= i_cfg.beep_on_ticks) begin
                            on_end            = 1'b1;
                            n_state.beep_step = STEP_GAP;
                        end
                    end
                    STEP_GAP: begin
                        tone_run = 1'b0;
                        if (phase_inc >= i_cfg.beep_gap_ticks) begin
                            n_state.beep_step   = STEP_ON2;
                            n_state.phase_count = '0;
                        end
                    end
                    STEP_ON2: begin
                        if (phase_inc >= i_cfg.beep_on_ticks) begin
                            on_end            = 1'b1;
                            n_state.beep_step = STEP_PAUSE;
                        end
                    end
                    default: begin
                        tone_run = 1'b0;
                        if (phase_inc >= i_cfg.beep_pause_ticks) begin
                            n_state.beep_step   = STEP_ON1;
                            n_state.phase_count = '0;
                        end
                    end
                endcase
            end
            // leaving an on step restarts the tone from a low pin
            if (on_end) begin
                n_state.phase_count = '0;
                tone_base = '0;
                pin_base  = 1'b0;
            end
            tone_inc = tone_base + 16'd1;
            if (tone_run) begin
                if (tone_inc >= r_state.half_period) begin
                    n_state.tone_count = '0;
                    n_state.pin_level  = ~pin_base;
                end else begin
                    n_state.tone_count = tone_inc;
                    n_state.pin_level  = pin_base;
                end
            end
        end
    end

    // result fields follow the updated state
    always_comb begin
        o_result.buzzer_level = n_state.pin_level;
        o_result.beep_phase   = n_state.beep_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.tone_enable   <= 1'b0;
            r_state.pattern_mode  <= 1'b0;
            r_state.half_period   <= '0;
            r_state.tone_count    <= '0;
            r_state.phase_count   <= '0;
            r_state.beep_step     <= STEP_ON1;
            r_state.pin_level     <= 1'b0;
            r_state.current_alert <= ALERT_SAFE;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    `ATPG_ASSERT_IMP(a_silent_pin_low, !r_state.tone_enable, !r_state.pin_level)
    `ATPG_ASSERT_IMP(a_safe_disables, r_state.current_alert == ALERT_SAFE, !r_state.tone_enable)
    `ATPG_ASSERT_NXT(a_no_pattern_step_hold,
        i_fire && !i_word.func && !r_state.pattern_mode, $stable(r_state.beep_step))
    `ATPG_ASSERT_NXT(a_quiet_step_pin_hold,
        i_fire && !i_word.func && (r_state.current_alert == ALERT_WARN) &&
        ((r_state.beep_step == STEP_GAP) || (r_state.beep_step == STEP_PAUSE)),
        $stable(r_state.pin_level))

endmodule

// ===== rtl/alert_tone_pattern_generator.sv =====
// channel   dir  word fields                         handshake
// i_in      in   func[0], alert_level[1:0]           valid/ready
// o_out     out  buzzer_level[0], beep_phase[1:0]    valid/ready
// i_cfg_*   in   index[2:0], data[15:0]              write enable, no wait
//
// path: a word accepted into the input register is worked on by the core
// combinationally and written to the result register when it moves on
// throughput: one word per cycle while the result register is not stalled, set by the single state update in the core
// reset: synchronous, active low; alert level safe, pin low, counters clear,
// config registers at their defaults
// stalls: the input register takes a word when it is empty or its word moves
// on; a word moves on when the result register is empty or its result is taken
module alert_tone_pattern_generator
    import atpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    atpg_in_if.sink              i_in,
    atpg_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data
);

    t_atpg_cfg      cfg;
    t_atpg_out_word core_result;

    // input register
    logic           r_in_valid;
    logic           n_in_valid;
    t_atpg_in_word  r_in_word;

    // result register
    logic           r_out_valid;
    logic           n_out_valid;
    t_atpg_out_word r_out_word;

    logic           advance;
    logic           in_take;

    // the core moves a word whenever the input register holds one and the result register is free or frees up
    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word.func        <= i_in.func;
            r_in_word.alert_level <= i_in.alert_level;
        end
        if (advance) begin
            r_out_word <= core_result;
        end
    end

    atpg_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    atpg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.buzzer_level = r_out_word.buzzer_level;
    assign o_out.beep_phase   = r_out_word.beep_phase;

endmodule
